FILE: design/cft_pkg.sv
// ============================================================================
// cft_pkg - shared types and constants of the circle fan tessellator
// Request and vertex beats, handshake groups of the shared multiplier and the
// serial divider, and the fixed-point constants of the trig series.
// ============================================================================
package cft_pkg;

    localparam int MAX_SEGMENTS   = 63;
    localparam int PHASE_BITS_DEF = 16;

    // 1.0 in Q62, and 2*pi in Q59 (that is pi/4 when read as Q62)
    localparam logic [63:0] Q62_ONE    = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TWO_PI_Q59 = 64'h3243_F6A8_885A_308D;

    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic        [14:0] radius;
        logic        [5:0]  segments;
        logic        [31:0] color;
    } t_req;

    typedef struct packed {
        logic               is_center;
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic        [31:0] vertex_color;
        logic        [5:0]  tri_first;
        logic        [5:0]  tri_second;
        logic        [5:0]  tri_third;
        logic               last;
    } t_vtx;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic         done;
        logic [127:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [7:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
        logic [7:0]  remainder;
    } t_div_rsp;

endpackage

FILE: design/cft_mul.sv
// ============================================================================
// cft_mul - shared 64x64 multiplier built on one 32x32 unit
// Four partial products, one per cycle, summed into a 128-bit accumulator.
// ============================================================================
module cft_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cft_pkg::t_mul_req i_req,
    output cft_pkg::t_mul_rsp o_rsp
);
    import cft_pkg::*;

    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_run;
    logic [1:0]   r_idx;
    logic [63:0]  r_pp;
    logic [1:0]   r_pp_off;
    logic         r_pp_vld;
    logic         r_pp_last;
    logic [127:0] r_acc;
    logic         r_done;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [63:0]  pp_full;
    logic [127:0] pp_ext;

    assign a_part  = r_idx[1] ? r_a[63:32] : r_a[31:0];
    assign b_part  = r_idx[0] ? r_b[63:32] : r_b[31:0];
    assign pp_full = a_part * b_part;
    assign pp_ext  = {64'd0, r_pp} << {r_pp_off, 5'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_pp_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= r_pp_vld && r_pp_last;
            if (i_req.start) begin
                r_a      <= i_req.a;
                r_b      <= i_req.b;
                r_idx    <= 2'd0;
                r_run    <= 1'b1;
                r_acc    <= '0;
                r_pp_vld <= 1'b0;
            end else begin
                r_pp_vld <= r_run;
                if (r_run) begin
                    r_pp      <= pp_full;
                    r_pp_off  <= {1'b0, r_idx[1]} + {1'b0, r_idx[0]};
                    r_pp_last <= (r_idx == 2'd3);
                    r_idx     <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        r_run <= 1'b0;
                    end
                end
                if (r_pp_vld) begin
                    r_acc <= r_acc + pp_ext;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

    // a new operand pair never lands on a product still being summed
    a_mul_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_run && !r_pp_vld)
        else $error("multiplier restarted while busy");

endmodule

FILE: design/cft_div.sv
// ============================================================================
// cft_div - serial divider, 64-bit dividend by 8-bit divisor
// Restoring long division, eight quotient bits per cycle.
// ============================================================================
module cft_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cft_pkg::t_div_req i_req,
    output cft_pkg::t_div_rsp o_rsp
);
    import cft_pkg::*;

    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = 64 / DIV_STEPS;
    localparam int CW         = $clog2(DIV_CYCLES);

    logic          r_run;
    logic [CW-1:0] r_cnt;
    logic [63:0]   r_num;
    logic [7:0]    r_rem;
    logic [7:0]    r_dvs;
    logic          r_done;

    logic [63:0]   n_num;
    logic [7:0]    n_rem;

    always_comb begin : p_step
        logic [8:0] v_wide;
        logic       v_qb;
        n_rem = r_rem;
        n_num = r_num;
        for (int s = 0; s < DIV_STEPS; s++) begin
            v_wide = {n_rem, n_num[63]};
            if (v_wide >= {1'b0, r_dvs}) begin
                n_rem = 8'(v_wide - {1'b0, r_dvs});
                v_qb  = 1'b1;
            end else begin
                n_rem = v_wide[7:0];
                v_qb  = 1'b0;
            end
            n_num = {n_num[62:0], v_qb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num <= i_req.dividend;
                r_rem <= 8'd0;
                r_dvs <= i_req.divisor;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DIV_CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_num;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: design/cft_vertex.sv
// ============================================================================
// cft_vertex - rim vertex sequencer
// Octant fold, Q62 sine/cosine series, Q15 rounding and the rim offset, all
// on the shared multiplier and the shared divider.
// ============================================================================
module cft_vertex #(
    parameter int PHASE_BITS = cft_pkg::PHASE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  logic [PHASE_BITS-1:0] i_phase,
    input  logic signed [15:0]    i_center_x,
    input  logic signed [15:0]    i_center_y,
    input  logic [14:0]           i_radius,
    output logic                  o_done,
    output logic signed [15:0]    o_vertex_x,
    output logic signed [15:0]    o_vertex_y,
    output cft_pkg::t_div_req     o_div_req,
    input  cft_pkg::t_div_rsp     i_div_rsp
);
    import cft_pkg::*;

    localparam int OCT_W = PHASE_BITS - 3;
    localparam int R_W   = PHASE_BITS - 2;
    localparam logic [R_W-1:0] OCT_SIZE = R_W'(1) << OCT_W;
    localparam logic [63:0]    STEP     = TWO_PI_Q59 >> OCT_W;

    typedef enum logic [10:0] {
        E_IDLE  = 11'h001,
        E_T     = 11'h002,
        E_T2    = 11'h004,
        E_SMUL  = 11'h008,
        E_SDIV  = 11'h010,
        E_SV    = 11'h020,
        E_CMUL  = 11'h040,
        E_CDIV  = 11'h080,
        E_ROUND = 11'h100,
        E_RX    = 11'h200,
        E_RY    = 11'h400
    } t_eng_state;

    function automatic logic [7:0] sin_div(input logic [2:0] k);
        unique case (k)
            3'd0:    return 8'd6;
            3'd1:    return 8'd20;
            3'd2:    return 8'd42;
            3'd3:    return 8'd72;
            3'd4:    return 8'd110;
            3'd5:    return 8'd156;
            3'd6:    return 8'd210;
            default: return 8'd1;
        endcase
    endfunction

    function automatic logic [7:0] cos_div(input logic [2:0] k);
        unique case (k)
            3'd0:    return 8'd2;
            3'd1:    return 8'd12;
            3'd2:    return 8'd30;
            3'd3:    return 8'd56;
            3'd4:    return 8'd90;
            3'd5:    return 8'd132;
            3'd6:    return 8'd182;
            default: return 8'd240;
        endcase
    endfunction

    // Q62 magnitude to Q15, ties away from zero, then the sign
    function automatic logic signed [16:0] round_q15(input logic [63:0] v, input logic neg);
        logic [63:0] s;
        logic [16:0] m;
        s = v + 64'h0000_4000_0000_0000;
        m = {1'b0, s[62:47]};
        return neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [15:0] trig_mag(input logic signed [16:0] v);
        logic [16:0] u;
        u = v;
        if (u[16]) begin
            u = ~u + 17'd1;
        end
        return u[15:0];
    endfunction

    function automatic logic signed [15:0] sat_add(input logic signed [15:0] c,
                                                   input logic [15:0] off,
                                                   input logic neg);
        logic signed [17:0] ce;
        logic signed [17:0] oe;
        logic signed [17:0] sum;
        ce  = $signed({{2{c[15]}}, c});
        oe  = $signed({2'b00, off});
        sum = neg ? (ce - oe) : (ce + oe);
        if (sum > 18'sd32767) begin
            return 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            return 16'sh8000;
        end
        return sum[15:0];
    endfunction

    t_eng_state         r_state;
    logic               r_wait;
    logic [2:0]         r_oct;
    logic [R_W-1:0]     r_r;
    logic [63:0]        r_t;
    logic [63:0]        r_t2;
    logic [63:0]        r_acc;
    logic [63:0]        r_m;
    logic [63:0]        r_sv;
    logic [2:0]         r_k;
    logic signed [16:0] r_sn;
    logic signed [16:0] r_cs;
    logic signed [15:0] r_vx;
    logic signed [15:0] r_vy;
    logic               r_done;

    t_mul_req           mul_req;
    t_mul_rsp           mul_rsp;
    logic [2:0]         oct_in;
    logic [OCT_W-1:0]   rr_in;
    logic [R_W-1:0]     r_in;
    logic [63:0]        q62;
    logic [63:0]        sb;
    logic [63:0]        cb;
    logic signed [16:0] sn_c;
    logic signed [16:0] cs_c;
    logic [31:0]        rnd_sum;
    logic [15:0]        off;
    logic               mul_state;

    cft_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // fold the phase into one octant; odd octants run backwards
    assign oct_in = i_phase[PHASE_BITS-1 -: 3];
    assign rr_in  = i_phase[OCT_W-1:0];
    assign r_in   = oct_in[0] ? (OCT_SIZE - R_W'(rr_in)) : R_W'(rr_in);

    assign q62     = mul_rsp.prod[125:62];
    assign rnd_sum = mul_rsp.prod[31:0] + 32'd16384;
    assign off     = rnd_sum[30:15];

    assign mul_state = (r_state == E_T) || (r_state == E_T2) || (r_state == E_SMUL) ||
                       (r_state == E_SV) || (r_state == E_CMUL) || (r_state == E_RX) ||
                       (r_state == E_RY);

    always_comb begin
        mul_req.start = mul_state && !r_wait;
        unique case (r_state)
            E_T: begin
                mul_req.a = 64'(r_r);
                mul_req.b = STEP;
            end
            E_T2: begin
                mul_req.a = r_t;
                mul_req.b = r_t;
            end
            E_SV: begin
                mul_req.a = r_t;
                mul_req.b = r_acc;
            end
            E_RX: begin
                mul_req.a = 64'(i_radius);
                mul_req.b = 64'(trig_mag(r_cs));
            end
            E_RY: begin
                mul_req.a = 64'(i_radius);
                mul_req.b = 64'(trig_mag(r_sn));
            end
            default: begin
                mul_req.a = r_t2;
                mul_req.b = r_acc;
            end
        endcase
    end

    assign o_div_req.start    = ((r_state == E_SDIV) || (r_state == E_CDIV)) && !r_wait;
    assign o_div_req.dividend = r_m;
    assign o_div_req.divisor  = (r_state == E_SDIV) ? sin_div(r_k) : cos_div(r_k);

    // octant mapping of the folded sine/cosine
    always_comb begin
        sb = r_oct[0] ? r_acc : r_sv;
        cb = r_oct[0] ? r_sv  : r_acc;
        unique case (r_oct[2:1])
            2'd0: begin
                sn_c = round_q15(sb, 1'b0);
                cs_c = round_q15(cb, 1'b0);
            end
            2'd1: begin
                sn_c = round_q15(cb, 1'b0);
                cs_c = round_q15(sb, 1'b1);
            end
            2'd2: begin
                sn_c = round_q15(sb, 1'b1);
                cs_c = round_q15(cb, 1'b1);
            end
            default: begin
                sn_c = round_q15(cb, 1'b1);
                cs_c = round_q15(sb, 1'b0);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_wait  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (mul_req.start || o_div_req.start) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_go) begin
                        r_oct   <= oct_in;
                        r_r     <= r_in;
                        r_state <= E_T;
                    end
                end
                E_T: begin
                    if (r_wait && mul_rsp.done) begin
                        r_t     <= mul_rsp.prod[63:0];
                        r_wait  <= 1'b0;
                        r_state <= E_T2;
                    end
                end
                E_T2: begin
                    if (r_wait && mul_rsp.done) begin
                        r_t2    <= q62;
                        r_acc   <= Q62_ONE;
                        r_k     <= 3'd6;
                        r_wait  <= 1'b0;
                        r_state <= E_SMUL;
                    end
                end
                E_SMUL: begin
                    if (r_wait && mul_rsp.done) begin
                        r_m     <= q62;
                        r_wait  <= 1'b0;
                        r_state <= E_SDIV;
                    end
                end
                E_SDIV: begin
                    if (r_wait && i_div_rsp.done) begin
                        r_acc  <= Q62_ONE - i_div_rsp.quotient;
                        r_wait <= 1'b0;
                        if (r_k == 3'd0) begin
                            r_state <= E_SV;
                        end else begin
                            r_k     <= r_k - 3'd1;
                            r_state <= E_SMUL;
                        end
                    end
                end
                E_SV: begin
                    if (r_wait && mul_rsp.done) begin
                        r_sv    <= q62;
                        r_acc   <= Q62_ONE;
                        r_k     <= 3'd7;
                        r_wait  <= 1'b0;
                        r_state <= E_CMUL;
                    end
                end
                E_CMUL: begin
                    if (r_wait && mul_rsp.done) begin
                        r_m     <= q62;
                        r_wait  <= 1'b0;
                        r_state <= E_CDIV;
                    end
                end
                E_CDIV: begin
                    if (r_wait && i_div_rsp.done) begin
                        r_acc  <= Q62_ONE - i_div_rsp.quotient;
                        r_wait <= 1'b0;
                        if (r_k == 3'd0) begin
                            r_state <= E_ROUND;
                        end else begin
                            r_k     <= r_k - 3'd1;
                            r_state <= E_CMUL;
                        end
                    end
                end
                E_ROUND: begin
                    r_sn    <= sn_c;
                    r_cs    <= cs_c;
                    r_state <= E_RX;
                end
                E_RX: begin
                    if (r_wait && mul_rsp.done) begin
                        r_vx    <= sat_add(i_center_x, off, r_cs[16]);
                        r_wait  <= 1'b0;
                        r_state <= E_RY;
                    end
                end
                E_RY: begin
                    if (r_wait && mul_rsp.done) begin
                        r_vy    <= sat_add(i_center_y, off, r_sn[16]);
                        r_wait  <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= E_IDLE;
                    end
                end
                default: begin
                    r_state <= E_IDLE;
                    r_wait  <= 1'b0;
                end
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_vertex_x = r_vx;
    assign o_vertex_y = r_vy;

endmodule

FILE: design/circle_fan_tessellator_core.sv
// ============================================================================
// circle_fan_tessellator_core - circle to triangle-fan vertex generator
// Turns one circle request into a center vertex and one rim vertex per
// segment, each rim vertex carrying its fan triangle indices.
// ============================================================================
// One request is taken when start is high and busy is low. The center vertex
// comes out on the next cycle; a request with zero segments ends there and
// busy stays low. Otherwise busy stays high until the last rim vertex. Setup
// runs one serial division for the phase step. For each rim vertex, the sine
// and cosine series run 18 64x64 products through the one shared 32x32
// multiplier and 15 serial divisions of a 64-bit value, two more products
// scale the radius, and the remaining steps are launch, rounding and
// hand-off. Every vertex is shown on o_vtx for exactly one cycle with
// o_strobe high; there is no back-pressure, the receiver must take each
// beat.
// Vertex indices assume empty output buffers: the center is always index 0.
// ============================================================================
module circle_fan_tessellator_core #(
    parameter int PHASE_BITS = cft_pkg::PHASE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  cft_pkg::t_req i_req,
    output logic          o_strobe,
    output cft_pkg::t_vtx o_vtx
);
    import cft_pkg::*;

    localparam logic [63:0] PHASE_ONE = 64'd1 << PHASE_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SETUP = 3'b010,
        S_VERT  = 3'b100
    } t_top_state;

    t_top_state          r_state;
    logic                r_launch;
    logic signed [15:0]  r_cx;
    logic signed [15:0]  r_cy;
    logic [14:0]         r_radius;
    logic [5:0]          r_seg;
    logic [31:0]         r_color;
    logic [5:0]          r_idx;
    logic [PHASE_BITS:0] r_q0;      // floor(2^PHASE_BITS / segments)
    logic [5:0]          r_rem0;    // matching remainder
    logic [5:0]          r_prem;    // running remainder of i*2^PHASE_BITS/segments
    logic [PHASE_BITS:0] r_phase;
    logic                r_strobe;
    t_vtx                r_vtx;

    logic                accept;
    logic [5:0]          seg_in;
    t_div_req            top_div_req;
    t_div_req            eng_div_req;
    t_div_req            div_req;
    t_div_rsp            div_rsp;
    logic                eng_go;
    logic                eng_done;
    logic signed [15:0]  eng_vx;
    logic signed [15:0]  eng_vy;
    logic [6:0]          rsum;
    logic                wrap;
    logic [5:0]          n_prem;
    logic [PHASE_BITS:0] n_phase;
    logic [5:0]          idx_next;
    logic                is_last;
    logic [5:0]          tri_third;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE) || !i_rst_n;

    // counts above the supported maximum are clamped
    assign seg_in = (i_req.segments > 6'(MAX_SEGMENTS)) ? 6'(MAX_SEGMENTS) : i_req.segments;

    // phase step setup: one division of a full turn by the segment count
    assign top_div_req.start    = (r_state == S_SETUP) && !r_launch;
    assign top_div_req.dividend = PHASE_ONE;
    assign top_div_req.divisor  = {2'b00, r_seg};

    // the divider is shared: setup owns it only while in S_SETUP
    assign div_req = (r_state == S_SETUP) ? top_div_req : eng_div_req;

    cft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign eng_go = (r_state == S_VERT) && !r_launch;

    cft_vertex #(
        .PHASE_BITS (PHASE_BITS)
    ) u_vertex (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (eng_go),
        .i_phase    (r_phase[PHASE_BITS-1:0]),
        .i_center_x (r_cx),
        .i_center_y (r_cy),
        .i_radius   (r_radius),
        .o_done     (eng_done),
        .o_vertex_x (eng_vx),
        .o_vertex_y (eng_vy),
        .o_div_req  (eng_div_req),
        .i_div_rsp  (div_rsp)
    );

    // next phase: add quotient and remainder, carry one when the remainder wraps
    assign rsum    = {1'b0, r_prem} + {1'b0, r_rem0};
    assign wrap    = (rsum >= {1'b0, r_seg});
    assign n_prem  = wrap ? 6'(rsum - {1'b0, r_seg}) : rsum[5:0];
    assign n_phase = r_phase + r_q0 + (PHASE_BITS+1)'(wrap);

    assign idx_next  = r_idx + 6'd1;
    assign is_last   = (idx_next == r_seg);
    assign tri_third = is_last ? 6'd1 : (r_idx + 6'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_launch <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cx                <= i_req.center_x;
                        r_cy                <= i_req.center_y;
                        r_radius            <= i_req.radius;
                        r_seg               <= seg_in;
                        r_color             <= i_req.color;
                        r_launch            <= 1'b0;
                        // center vertex goes out right away
                        r_strobe            <= 1'b1;
                        r_vtx.is_center     <= 1'b1;
                        r_vtx.vertex_x      <= i_req.center_x;
                        r_vtx.vertex_y      <= i_req.center_y;
                        r_vtx.vertex_color  <= i_req.color;
                        r_vtx.tri_first     <= 6'd0;
                        r_vtx.tri_second    <= 6'd0;
                        r_vtx.tri_third     <= 6'd0;
                        r_vtx.last          <= (seg_in == 6'd0);
                        r_state             <= (seg_in == 6'd0) ? S_IDLE : S_SETUP;
                    end
                end
                S_SETUP: begin
                    if (top_div_req.start) begin
                        r_launch <= 1'b1;
                    end
                    if (r_launch && div_rsp.done) begin
                        r_q0     <= div_rsp.quotient[PHASE_BITS:0];
                        r_rem0   <= div_rsp.remainder[5:0];
                        r_phase  <= '0;
                        r_prem   <= 6'd0;
                        r_idx    <= 6'd0;
                        r_launch <= 1'b0;
                        r_state  <= S_VERT;
                    end
                end
                S_VERT: begin
                    if (eng_go) begin
                        r_launch <= 1'b1;
                    end
                    if (r_launch && eng_done) begin
                        r_strobe            <= 1'b1;
                        r_vtx.is_center     <= 1'b0;
                        r_vtx.vertex_x      <= eng_vx;
                        r_vtx.vertex_y      <= eng_vy;
                        r_vtx.vertex_color  <= r_color;
                        r_vtx.tri_first     <= 6'd0;
                        r_vtx.tri_second    <= idx_next;
                        r_vtx.tri_third     <= tri_third;
                        r_vtx.last          <= is_last;
                        r_phase             <= n_phase;
                        r_prem              <= n_prem;
                        r_idx               <= idx_next;
                        r_launch            <= 1'b0;
                        if (is_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state  <= S_IDLE;
                    r_launch <= 1'b0;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_vtx    = r_vtx;

    // every accepted request opens with its center vertex on the next cycle
    a_center_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_strobe && o_vtx.is_center)
        else $error("center vertex did not follow request");

    // the final rim vertex leaves the block ready for the next request
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_vtx.is_center && o_vtx.last |-> r_state == S_IDLE)
        else $error("busy after final rim vertex");

    // only the closing triangle wraps back to rim vertex one
    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_vtx.is_center |-> o_vtx.last == (o_vtx.tri_third == 6'd1))
        else $error("fan wrap index out of step with last");

endmodule
